@@ rtl/dq_pkg.sv @@
// shared types and constants for the bounded deque with search
// no dependencies; used by dq_cell, dq_find and bounded_deque_with_search
package dq_pkg;

  localparam int VALUE_W       = 32;
  localparam int ACTION_W      = 3;
  localparam int FIELD_W       = 7;
  localparam int DEPTH_DEFAULT = 64;
  // cells per group in the per-group stage of the match search
  localparam int GROUP_SIZE    = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_SEARCH     = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_DONE
  } state_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic push_front;
    logic pop_front;
    logic push_back;
    logic search;
  } cell_ctrl_t;

endpackage

@@ rtl/dq_cell.sv @@
// one storage cell of the deque chain: holds an entry, shifts towards either
// neighbour and compares its entry against the search key
// depends on dq_pkg
module dq_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  dq_pkg::cell_ctrl_t                  ctrl,
  input  logic                                occupied,
  input  logic                                load_here,
  input  logic signed [dq_pkg::VALUE_W-1:0]   value,
  input  logic signed [dq_pkg::VALUE_W-1:0]   from_prev,
  input  logic signed [dq_pkg::VALUE_W-1:0]   from_next,
  output logic signed [dq_pkg::VALUE_W-1:0]   entry,
  output logic                                match
);

  // entry storage: shift towards the back, shift towards the front, or load
  always_ff @(posedge clk) begin
    if (ctrl.push_front) begin
      entry <= from_prev;
    end else if (ctrl.pop_front) begin
      entry <= from_next;
    end else if (ctrl.push_back && load_here) begin
      entry <= value;
    end
  end

  // registered compare against the key, only for held entries
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else begin
      match <= ctrl.search && occupied && (entry == value);
    end
  end

endmodule

@@ rtl/dq_find.sv @@
// first-match finder over the cell match bits: a registered per-group stage
// followed by a priority pick across groups; depends on dq_pkg
module dq_find #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [DEPTH-1:0]            match,
  output logic                        found,
  output logic [dq_pkg::FIELD_W-1:0]  position
);

  localparam int GROUP = dq_pkg::GROUP_SIZE;
  localparam int NGRP  = (DEPTH + GROUP - 1) / GROUP;
  localparam int PAD   = NGRP * GROUP;
  localparam int LW    = $clog2(GROUP);
  localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PW    = GW + LW;
  localparam int FW    = dq_pkg::FIELD_W;

  logic [PAD-1:0] match_pad;
  logic           grp_hit [NGRP];
  logic [LW-1:0]  grp_idx [NGRP];
  logic [GW-1:0]  sel;
  logic [PW:0]    pos_full;

  function automatic logic [LW-1:0] first_one(input logic [GROUP-1:0] v);
    logic [LW-1:0] r;
    r = '0;
    for (int i = GROUP - 1; i >= 0; i--) begin
      if (v[i]) r = LW'(i);
    end
    return r;
  endfunction

  assign match_pad = PAD'(match);

  // group stage: any hit and lowest hit index within each group
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NGRP; g++) grp_hit[g] <= 1'b0;
    end else if (en) begin
      for (int g = 0; g < NGRP; g++) grp_hit[g] <= |match_pad[g*GROUP +: GROUP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NGRP; g++) grp_idx[g] <= first_one(match_pad[g*GROUP +: GROUP]);
    end
  end

  // lowest group holding a hit
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        found = 1'b1;
        sel   = GW'(g);
      end
    end
  end

  // one-based position, reduced to the field width
  assign pos_full = {1'b0, sel, grp_idx[sel]} + (PW+1)'(1);
  assign position = found ? FW'(pos_full) : '0;

endmodule

@@ rtl/bounded_deque_with_search.sv @@
// Bounded double-ended queue of signed 32-bit values with first-match search,
// built as a chain of DEPTH cells that shift towards either end. Push, pop and
// unknown actions pass from the idle state to the done state, which loads the
// result into the output register. A search passes through the match state
// before done: the cell compare is registered, then a per-group first-match
// stage, then a priority pick across groups. The sequencer works on one
// transaction at a time; a finished result waits in the output register while
// the next transaction is accepted, and a result still waiting there holds the
// sequencer until it is taken. Depends on dq_pkg, dq_cell and dq_find.
module bounded_deque_with_search #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dq_pkg::ACTION_W-1:0]         action,
  input  logic signed [dq_pkg::VALUE_W-1:0]   value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                ok,
  output logic [dq_pkg::FIELD_W-1:0]          position,
  output logic                                is_empty,
  output logic [dq_pkg::FIELD_W-1:0]          count
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int FW    = dq_pkg::FIELD_W;

  dq_pkg::state_t     state, state_next;
  dq_pkg::cell_ctrl_t ctrl;
  logic [CNT_W-1:0]   held, held_next;
  logic               res_ok, res_ok_next;
  logic               res_search, res_search_next;
  logic               accept;
  logic               out_load;
  logic               find_en;
  logic               found;
  logic [FW-1:0]      found_pos;
  logic               is_full, is_void;

  logic signed [dq_pkg::VALUE_W-1:0] entry [DEPTH];
  logic [DEPTH-1:0]                  match;

  assign in_ready = (state == dq_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_full  = (held == CNT_W'(DEPTH));
  assign is_void  = (held == '0);
  assign find_en  = (state == dq_pkg::ST_MATCH);
  assign out_load = (state == dq_pkg::ST_DONE) && (!out_valid || out_ready);

  // sequencer: next state, cell command and count update
  always_comb begin
    state_next      = state;
    held_next       = held;
    res_ok_next     = res_ok;
    res_search_next = res_search;
    ctrl            = '0;
    case (state)
      dq_pkg::ST_IDLE: begin
        if (accept) begin
          res_ok_next     = 1'b0;
          res_search_next = 1'b0;
          state_next      = dq_pkg::ST_DONE;
          case (dq_pkg::action_t'(action))
            dq_pkg::ACT_PUSH_FRONT: begin
              if (!is_full) begin
                ctrl.push_front = 1'b1;
                held_next       = held + CNT_W'(1);
                res_ok_next     = 1'b1;
              end
            end
            dq_pkg::ACT_PUSH_BACK: begin
              if (!is_full) begin
                ctrl.push_back = 1'b1;
                held_next      = held + CNT_W'(1);
                res_ok_next    = 1'b1;
              end
            end
            dq_pkg::ACT_POP_FRONT: begin
              if (!is_void) begin
                ctrl.pop_front = 1'b1;
                held_next      = held - CNT_W'(1);
                res_ok_next    = 1'b1;
              end
            end
            dq_pkg::ACT_POP_BACK: begin
              if (!is_void) begin
                held_next   = held - CNT_W'(1);
                res_ok_next = 1'b1;
              end
            end
            dq_pkg::ACT_SEARCH: begin
              ctrl.search     = 1'b1;
              res_search_next = 1'b1;
              state_next      = dq_pkg::ST_MATCH;
            end
            default: begin
            end
          endcase
        end
      end
      dq_pkg::ST_MATCH: begin
        state_next = dq_pkg::ST_DONE;
      end
      dq_pkg::ST_DONE: begin
        if (out_load) state_next = dq_pkg::ST_IDLE;
      end
      default: begin
        state_next = dq_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dq_pkg::ST_IDLE;
      held       <= '0;
      res_ok     <= 1'b0;
      res_search <= 1'b0;
    end else begin
      state      <= state_next;
      held       <= held_next;
      res_ok     <= res_ok_next;
      res_search <= res_search_next;
    end
  end

  // output register: holds the result until the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ok       <= res_search ? found : res_ok;
      position <= res_search ? found_pos : '0;
      is_empty <= is_void;
      count    <= FW'(held);
    end
  end

  // chain of cells, front at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [dq_pkg::VALUE_W-1:0] prev_entry;
    logic signed [dq_pkg::VALUE_W-1:0] next_entry;

    if (i == 0) begin : g_front
      assign prev_entry = value;
    end else begin : g_mid_prev
      assign prev_entry = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign next_entry = entry[i];
    end else begin : g_mid_next
      assign next_entry = entry[i+1];
    end

    dq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .occupied  (CNT_W'(i) < held),
      .load_here (held == CNT_W'(i)),
      .value     (value),
      .from_prev (prev_entry),
      .from_next (next_entry),
      .entry     (entry[i]),
      .match     (match[i])
    );
  end

  dq_find #(
    .DEPTH (DEPTH)
  ) u_find (
    .clk      (clk),
    .rst      (rst),
    .en       (find_en),
    .match    (match),
    .found    (found),
    .position (found_pos)
  );

  // the count never exceeds the capacity
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(DEPTH))
    else $error("element count above capacity");

  // the count moves only on an accepted transaction
  a_held_still: assert property (@(posedge clk) disable iff (rst)
    !accept |=> held == $past(held))
    else $error("element count changed without a transaction");

  // a search goes through the match stage before its result
  a_search_path: assert property (@(posedge clk) disable iff (rst)
    accept && (action == dq_pkg::ACT_SEARCH) |=> state == dq_pkg::ST_MATCH)
    else $error("search skipped the match stage");

  // a reported position is always a successful match
  a_pos_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (position != '0) |-> ok)
    else $error("position reported without success");

endmodule
